// File: design/generational_handle_allocator_assert.svh
// Assertion macros for the generational handle allocator.
// Depends on nothing; included by the top level only.
`ifndef GENERATIONAL_HANDLE_ALLOCATOR_ASSERT_SVH
`define GENERATIONAL_HANDLE_ALLOCATOR_ASSERT_SVH

// Check that a condition implies another in the same cycle.
`define GHA_ASSERT_SAME(label, clk, rst_n, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
		else $error("same-cycle implication failed");

// Check that a condition implies another in the next cycle.
`define GHA_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
		else $error("next-cycle implication failed");

`endif

// File: design/gha_pkg.sv
// Package of the generational handle allocator: sizes, codes and item types.
// Depends on nothing; used by gha_free_find and the top level.
package gha_pkg;

	localparam int SLOTS = 64;
	localparam int GEN_BITS = 16;
	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	localparam int SLOT_FIELD_W = 6;
	localparam int GEN_FIELD_W = 16;

	typedef logic [SLOT_W-1:0] slot_t;
	typedef logic [GEN_BITS-1:0] gen_t;

	localparam logic [1:0] MODE_CREATE = 2'd0;
	localparam logic [1:0] MODE_CHECK = 2'd1;
	localparam logic [1:0] MODE_REMOVE = 2'd2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_STALE = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic [1:0] mode;
		logic [SLOT_FIELD_W-1:0] slot_index;
		logic [GEN_FIELD_W-1:0] handle_generation;
	} req_t;

	typedef struct packed {
		logic [SLOT_FIELD_W-1:0] result_slot;
		logic [GEN_FIELD_W-1:0] result_generation;
		logic [1:0] status;
	} rsp_t;

	// Result of the free-slot search
	typedef struct packed {
		logic found;
		slot_t index;
	} free_t;

endpackage

// File: design/gha_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// Depends on nothing.
module gha_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic clk,
	input  logic we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: design/gha_free_find.sv
// Lowest-free-slot search over the in-use vector.
// Depends on gha_pkg.
module gha_free_find (
	input  logic [gha_pkg::SLOTS-1:0] used,
	output gha_pkg::free_t free
);
	import gha_pkg::*;

	logic [SLOTS-1:0] free_vec;
	logic [SLOTS-1:0] lowest;

	// Bits of the one-hot vector whose position has bit b set
	function automatic logic [SLOTS-1:0] pos_mask(input int b);
		logic [SLOTS-1:0] m;
		m = '0;
		for (int i = 0; i < SLOTS; i++) begin
			m[i] = ((i >> b) & 1) != 0;
		end
		return m;
	endfunction

	// Isolate the lowest set bit, then encode it
	assign free_vec = ~used;
	assign lowest = free_vec & (~free_vec + {{(SLOTS-1){1'b0}}, 1'b1});

	always_comb begin
		free.found = |free_vec;
		for (int b = 0; b < SLOT_W; b++) begin
			free.index[b] = |(lowest & pos_mask(b));
		end
	end

endmodule

// File: design/generational_handle_allocator.sv
// Top level of the generational handle allocator: slot table and control.
// Depends on gha_pkg, gha_ram, gha_free_find and the assertion header.
//
// Usage:
//   req channel (req_valid, req_stall, req) carries one command item:
//   create, check or remove of a handle. rsp channel (rsp_valid, rsp_stall,
//   rsp) returns exactly one result item per command, in order.
//   An item moves at a clock edge with valid high and stall low.
// Operation:
//   On acceptance the block picks the slot (lowest free slot on create,
//   else the handle's slot) and reads the generation RAM. Stage 1 then takes
//   the registered read and forms the result; once the output register is
//   free it writes back the generation on remove, updates the in-use vector
//   and loads the result into the output register. A new item is accepted
//   only while stage 1 is empty, so no command enters before the last has left.
// Reset:
//   arst_n clears the in-use vector and the per-slot written marks, so every
//   slot reads as free at generation 0 right away; no clearing pass.
// Stall:
//   A result waits in the output register while rsp_stall is high; the next
//   item may be accepted meanwhile and then holds in stage 1 until the
//   output register frees up.
module generational_handle_allocator (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  gha_pkg::req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output gha_pkg::rsp_t rsp
);
	import gha_pkg::*;

	`include "generational_handle_allocator_assert.svh"

	// Slot state: in-use marks and written marks in flip-flops
	logic [SLOTS-1:0] used_q;
	logic [SLOTS-1:0] gen_valid_q;

	free_t free;

	// Stage 1 registers
	logic s1_valid;
	logic [1:0] op_s1;
	slot_t addr_s1;
	logic [SLOT_FIELD_W-1:0] echo_s1;
	gen_t hgen_s1;
	logic in_range_s1;
	logic found_s1;

	logic req_acc;
	logic s1_done;
	slot_t rd_addr;
	logic in_range;
	gen_t rdata;
	gen_t cur_gen;
	gen_t inc_gen;
	logic wr_en;
	rsp_t rsp_next;
	logic rsp_valid_q;
	rsp_t rsp_q;

	// Accept only while stage 1 is empty
	assign req_stall = s1_valid;
	assign req_acc = req_valid && !req_stall;

	gha_free_find u_free_find (
		.used (used_q),
		.free (free)
	);

	// Pick the slot: lowest free on create, handle's slot otherwise
	assign in_range = 32'(req.slot_index) < 32'(SLOTS);
	assign rd_addr = (req.mode == MODE_CREATE) ? free.index : SLOT_W'(req.slot_index);

	gha_ram #(
		.WIDTH (GEN_BITS),
		.DEPTH (SLOTS)
	) u_gen_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (addr_s1),
		.wdata (inc_gen),
		.re    (req_acc),
		.raddr (rd_addr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (req_acc) begin
			s1_valid <= 1'b1;
		end else if (s1_done) begin
			s1_valid <= 1'b0;
		end
	end

	// Capture the command alongside the RAM read
	always_ff @(posedge clk) begin
		if (req_acc) begin
			op_s1 <= req.mode;
			addr_s1 <= rd_addr;
			echo_s1 <= req.slot_index;
			hgen_s1 <= gen_t'(req.handle_generation);
			in_range_s1 <= in_range;
			found_s1 <= free.found;
		end
	end

	// A slot never written reads as generation 0
	assign cur_gen = gen_valid_q[addr_s1] ? rdata : '0;
	assign inc_gen = cur_gen + gen_t'(1);

	// Advance when the output register is free or being emptied
	assign s1_done = s1_valid && (!rsp_valid_q || !rsp_stall);
	assign wr_en = s1_done && (op_s1 == MODE_REMOVE) && in_range_s1;

	always_comb begin
		rsp_next.result_slot = echo_s1;
		rsp_next.result_generation = '0;
		rsp_next.status = ST_OK;
		unique case (op_s1)
			MODE_CREATE: begin
				if (found_s1) begin
					rsp_next.result_slot = SLOT_FIELD_W'(addr_s1);
					rsp_next.result_generation = GEN_FIELD_W'(cur_gen);
				end else begin
					rsp_next.result_slot = '0;
					rsp_next.status = ST_FULL;
				end
			end
			MODE_CHECK: begin
				if (in_range_s1) begin
					rsp_next.result_generation = GEN_FIELD_W'(cur_gen);
					rsp_next.status = (hgen_s1 == cur_gen) ? ST_OK : ST_STALE;
				end else begin
					rsp_next.status = ST_STALE;
				end
			end
			MODE_REMOVE: begin
				if (in_range_s1) begin
					rsp_next.result_generation = GEN_FIELD_W'(inc_gen);
				end
			end
			default: begin
				rsp_next.status = ST_OK;
			end
		endcase
	end

	// Update slot marks at the write-back edge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			gen_valid_q <= '0;
		end else if (s1_done) begin
			if (op_s1 == MODE_CREATE && found_s1) begin
				used_q[addr_s1] <= 1'b1;
			end
			if (wr_en) begin
				used_q[addr_s1] <= 1'b0;
				gen_valid_q[addr_s1] <= 1'b1;
			end
		end
	end

	// Output register: hold while stalled, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (s1_done) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_done) begin
			rsp_q <= rsp_next;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	// A blocked stage 1 keeps its item
	`GHA_ASSERT_NEXT(a_s1_hold, clk, arst_n, s1_valid && rsp_valid_q && rsp_stall, s1_valid)
	// RAM writes come only from a completing remove
	`GHA_ASSERT_SAME(a_wr_src, clk, arst_n, wr_en, s1_done && op_s1 == MODE_REMOVE)
	// A granted create leaves its slot marked used
	`GHA_ASSERT_NEXT(a_create_used, clk, arst_n, s1_done && op_s1 == MODE_CREATE && found_s1, used_q[$past(addr_s1)])
	// A new result only follows a stage 1 item
	`GHA_ASSERT_SAME(a_rsp_src, clk, arst_n, $rose(rsp_valid_q), $past(s1_valid))

endmodule

// File: tb/sv/generational_handle_allocator_tb.sv
// Self-checking testbench for the generational handle allocator: a directed table, then
// random create/check/remove traffic, checked against a slot map model in the bench.
// Depends on gha_pkg and the generational_handle_allocator top level.
module generational_handle_allocator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import gha_pkg::*;

	// Mode 3 has no name in the package; the block treats it as a no-op echo
	localparam logic [1:0] MODE_SPARE = 2'd3;

	localparam int LONG_HOLD = 48;
	localparam int TAIL_CYCLES = 10;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int MAX_PRINTED = 30;

	typedef struct {
		req_t item;
		bit typed;
		rsp_t want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	// Model of the slot map: in-use marks and generation counters
	bit slot_taken [SLOTS];
	gen_t slot_gen [SLOTS];

	rsp_t awaited_rsp [$];
	dir_row_t dir_rows [$];

	int errors = 0;
	int items_sent = 0;
	int results_seen = 0;
	int full_seen = 0;
	int stale_seen = 0;
	int idle_cycles = 0;

	// Receiver control: burst countdown and long hold-off requests from the sender
	int rx_left = 0;
	int hold_asked = 0;
	int hold_given = 0;
	bit quiet = 1'b0;

	generational_handle_allocator dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	task automatic flag_mismatch(input string what);
		errors++;
		if (errors <= MAX_PRINTED) begin
			$display("[%0t] MISMATCH: %s", $realtime, what);
		end
	endtask

	// Add one row at the end of the directed table
	task automatic append_row(input dir_row_t d);
		dir_rows = {dir_rows, d};
	endtask

	// Apply one command to the slot map model and return the result it should produce
	function automatic rsp_t slot_map_step(input req_t item);
		rsp_t r;
		bit found;
		int idx;
		r = '0;
		found = 1'b0;
		idx = int'(item.slot_index);
		case (item.mode)
			MODE_CREATE: begin
				// Lowest free slot wins; a full map changes nothing
				for (int i = 0; i < SLOTS; i++) begin
					if (!found && !slot_taken[i]) begin
						found = 1'b1;
						slot_taken[i] = 1'b1;
						r.result_slot = SLOT_FIELD_W'(i);
						r.result_generation = GEN_FIELD_W'(slot_gen[i]);
					end
				end
				r.status = found ? ST_OK : ST_FULL;
			end
			MODE_CHECK: begin
				r.result_slot = item.slot_index;
				if (idx >= SLOTS) begin
					r.status = ST_STALE;
				end else begin
					r.result_generation = GEN_FIELD_W'(slot_gen[idx]);
					r.status = (gen_t'(item.handle_generation) == slot_gen[idx]) ? ST_OK : ST_STALE;
				end
			end
			MODE_REMOVE: begin
				r.result_slot = item.slot_index;
				r.status = ST_OK;
				// Free and bump the generation even if the slot was already free
				if (idx < SLOTS) begin
					slot_taken[idx] = 1'b0;
					slot_gen[idx] = slot_gen[idx] + 1'b1;
					r.result_generation = GEN_FIELD_W'(slot_gen[idx]);
				end
			end
			default: begin
				r.result_slot = item.slot_index;
				r.status = ST_OK;
			end
		endcase
		return r;
	endfunction

	function automatic dir_row_t row(input logic [1:0] mode, input int slot, input int gen,
			input bit typed, input int want_slot, input int want_gen, input logic [1:0] want_st);
		dir_row_t d;
		d.item.mode = mode;
		d.item.slot_index = SLOT_FIELD_W'(slot);
		d.item.handle_generation = GEN_FIELD_W'(gen);
		d.typed = typed;
		d.want.result_slot = SLOT_FIELD_W'(want_slot);
		d.want.result_generation = GEN_FIELD_W'(want_gen);
		d.want.status = want_st;
		return d;
	endfunction

	// Random slot that is in use, or a random slot if the map is empty
	function automatic int taken_slot();
		int start;
		start = $urandom_range(0, SLOTS - 1);
		for (int k = 0; k < SLOTS; k++) begin
			if (slot_taken[(start + k) % SLOTS]) begin
				return (start + k) % SLOTS;
			end
		end
		return start;
	endfunction

	function automatic req_t random_item(input int create_pct, input int check_pct,
			input int remove_pct);
		req_t item;
		int roll;
		// Ignored fields still carry random content
		item.slot_index = SLOT_FIELD_W'($urandom);
		item.handle_generation = GEN_FIELD_W'($urandom);
		roll = $urandom_range(0, 99);
		if (roll < create_pct) begin
			item.mode = MODE_CREATE;
		end else if (roll < create_pct + check_pct) begin
			item.mode = MODE_CHECK;
			if ($urandom_range(0, 1) == 0) begin
				item.slot_index = SLOT_FIELD_W'(taken_slot());
			end
			// Mostly live handles, some one generation behind, the rest random
			case ($urandom_range(0, 3))
				0, 1: item.handle_generation = GEN_FIELD_W'(slot_gen[item.slot_index]);
				2: item.handle_generation = GEN_FIELD_W'(slot_gen[item.slot_index] - 1'b1);
				default: ;
			endcase
		end else if (roll < create_pct + check_pct + remove_pct) begin
			item.mode = MODE_REMOVE;
			if ($urandom_range(0, 3) != 0) begin
				item.slot_index = SLOT_FIELD_W'(taken_slot());
			end
		end else begin
			item.mode = MODE_SPARE;
		end
		return item;
	endfunction

	// Queue the expected result, then offer the item until it is accepted
	task automatic send_item(input req_t item, input bit typed, input rsp_t want);
		rsp_t predicted;
		predicted = slot_map_step(item);
		awaited_rsp = {awaited_rsp, (typed ? want : predicted)};
		items_sent++;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		@(posedge clk);
		while (req_stall) @(posedge clk);
	endtask

	// Drop valid and hold the sender until every expected result is back
	task automatic drain_results();
		req_valid <= 1'b0;
		while (awaited_rsp.size() != 0) @(posedge clk);
	endtask

	task automatic run_phase(input int count, input int create_pct, input int check_pct,
			input int remove_pct);
		rsp_t none;
		none = '0;
		for (int n = 0; n < count; n++) begin
			send_item(random_item(create_pct, check_pct, remove_pct), 1'b0, none);
		end
	endtask

	// Receiver: random stall bursts, plus a long hold-off counted here on request
	always @(posedge clk) begin
		if (rx_left != 0) begin
			rsp_stall <= 1'b1;
			rx_left <= rx_left - 1;
		end else if (hold_given != hold_asked) begin
			rsp_stall <= 1'b1;
			rx_left <= LONG_HOLD - 1;
			hold_given <= hold_given + 1;
		end else if (!quiet && $urandom_range(0, 9) == 0) begin
			rsp_stall <= 1'b1;
			rx_left <= $urandom_range(0, 11);
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	// Compare each accepted result with the oldest expectation
	always @(posedge clk) begin : rsp_check
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			results_seen++;
			if (awaited_rsp.size() == 0) begin
				flag_mismatch($sformatf("unexpected result slot %0d gen %0d status %0d",
					rsp.result_slot, rsp.result_generation, rsp.status));
			end else begin
				want = awaited_rsp.pop_front();
				if (want.status == ST_FULL) full_seen++;
				if (want.status == ST_STALE) stale_seen++;
				if (rsp.result_slot !== want.result_slot) begin
					flag_mismatch($sformatf("result_slot %0d, expected %0d",
						rsp.result_slot, want.result_slot));
				end
				if (rsp.result_generation !== want.result_generation) begin
					flag_mismatch($sformatf("result_generation %0d, expected %0d",
						rsp.result_generation, want.result_generation));
				end
				if (rsp.status !== want.status) begin
					flag_mismatch($sformatf("status %0d, expected %0d",
						rsp.status, want.status));
				end
			end
		end
	end

	// Watchdog: end the run if no item moves on either side for too long
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
				$display("watchdog: no item moved for %0d cycles, %0d results outstanding",
					WATCHDOG_LIMIT, awaited_rsp.size());
				$display("generational_handle_allocator: mismatch");
				$finish;
			end
		end
	end

	initial begin : stimulus
		rsp_t none;
		none = '0;
		for (int i = 0; i < SLOTS; i++) begin
			slot_taken[i] = 1'b0;
			slot_gen[i] = '0;
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table: fresh map, generation compare, free-slot remove, spare mode
		append_row(row(MODE_CREATE, 63, 16'hFFFF, 1, 0, 0, ST_OK));
		append_row(row(MODE_CREATE, 0, 0, 1, 1, 0, ST_OK));
		append_row(row(MODE_CHECK, 0, 0, 1, 0, 0, ST_OK));
		append_row(row(MODE_CHECK, 0, 16'hFFFF, 1, 0, 0, ST_STALE));
		append_row(row(MODE_CHECK, 63, 0, 1, 63, 0, ST_OK));
		append_row(row(MODE_CHECK, 63, 16'hFFFF, 1, 63, 0, ST_STALE));
		append_row(row(MODE_REMOVE, 0, 16'hFFFF, 1, 0, 1, ST_OK));
		append_row(row(MODE_CHECK, 0, 0, 1, 0, 1, ST_STALE));
		append_row(row(MODE_CHECK, 0, 1, 1, 0, 1, ST_OK));
		append_row(row(MODE_CREATE, 0, 0, 1, 0, 1, ST_OK));
		append_row(row(MODE_REMOVE, 63, 0, 1, 63, 1, ST_OK));
		append_row(row(MODE_REMOVE, 63, 16'hFFFF, 1, 63, 2, ST_OK));
		append_row(row(MODE_CREATE, 63, 16'hFFFF, 1, 2, 0, ST_OK));
		append_row(row(MODE_SPARE, 63, 16'hFFFF, 1, 63, 0, ST_OK));
		append_row(row(MODE_SPARE, 0, 0, 1, 0, 0, ST_OK));
		append_row(row(MODE_REMOVE, 42, 16'hAAAA, 0, 0, 0, ST_OK));
		append_row(row(MODE_CHECK, 21, 16'h5555, 0, 0, 0, ST_OK));
		append_row(row(MODE_REMOVE, 1, 16'h5555, 0, 0, 0, ST_OK));
		append_row(row(MODE_CREATE, 42, 16'hAAAA, 0, 0, 0, ST_OK));
		append_row(row(MODE_CHECK, 2, 0, 0, 0, 0, ST_OK));
		append_row(row(MODE_CHECK, 63, 2, 0, 0, 0, ST_OK));
		foreach (dir_rows[i]) begin
			send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
		end
		drain_results();

		// Create-heavy traffic that fills the map so creates report it full
		run_phase(350, 70, 20, 5);
		drain_results();

		// Hold the output side for a long stretch while items keep coming
		hold_asked <= hold_asked + 1;
		run_phase(400, 40, 30, 25);
		drain_results();

		// Drain, then refill
		run_phase(350, 10, 30, 55);
		drain_results();
		run_phase(400, 60, 20, 15);
		drain_results();

		// Last stretch at full rate with no idling on either side
		quiet <= 1'b1;
		run_phase(400, 35, 30, 30);
		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Sent %0d items (%0d from the directed table), checked %0d results.",
			items_sent, dir_rows.size(), results_seen);
		$display("Saw %0d table-full and %0d stale results over fill, drain and hold-off phases.",
			full_seen, stale_seen);
		if (errors == 0 && awaited_rsp.size() == 0) begin
			$display("generational_handle_allocator: match");
		end else begin
			$display("generational_handle_allocator: mismatch");
		end
		$finish;
	end

endmodule
